### sv/led_strip_segment_animator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LED strip segment animator
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_SEGMENT_ANIMATOR_ASSERT_SVH
`define LED_STRIP_SEGMENT_ANIMATOR_ASSERT_SVH

// Same-cycle implication.
`define LSSA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lssa assertion failed");

// Next-cycle implication.
`define LSSA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lssa assertion failed");

`endif

### sv/lssa_pkg.sv
// ----------------------------------------------------------------------------
// lssa_pkg
// Types and constants shared by the LED strip segment animator.
// ----------------------------------------------------------------------------
package lssa_pkg;

  localparam int STRIP_PIXELS  = 64;
  localparam int TABLE_DEPTH   = 64;
  localparam int FRAME_RATE    = 30;
  localparam int MS_PER_SECOND = 1000;
  localparam int DURATION_MAX  = 2047;

  localparam int DUR_W     = 11;
  localparam int LEN_W     = 7;
  localparam int OFF_W     = 7;
  localparam int SEG_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int DIV_NUM_W = 21;
  localparam int DIV_DEN_W = 11;
  localparam int SEG_W     = 24 + DUR_W + LEN_W + 1;

  // Milliseconds to frames by reciprocal multiplication.
  localparam int MS_PROD_W   = 16 + $clog2(FRAME_RATE + 1);
  localparam int MS_SHIFT    = MS_PROD_W + $clog2(MS_PER_SECOND);
  localparam int MS_RECIP_W  = MS_SHIFT - $clog2(MS_PER_SECOND) + 1;
  localparam int MS_SCALED_W = MS_PROD_W + MS_RECIP_W;
  localparam longint unsigned MS_RECIP =
    ((64'd1 << MS_SHIFT) + MS_PER_SECOND - 1) / MS_PER_SECOND;

  typedef logic [23:0] color_t;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_APPEND = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

endpackage

### sv/lssa_div.sv
// ----------------------------------------------------------------------------
// lssa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lssa_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lssa_pkg::DIV_NUM_W-1:0] num,
  input  logic [lssa_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [lssa_pkg::DIV_NUM_W-1:0] quot
);
  import lssa_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [DIV_NUM_W-1:0] work;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dreg;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] diff;
  logic                 ge;

  assign rem_sh = {rem, work[DIV_NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dreg};
  assign ge     = ~diff[DIV_DEN_W+1];
  assign quot   = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NUM_W);
        work <= num;
        rem  <= '0;
        dreg <= den;
      end else if (busy) begin
        work <= {work[DIV_NUM_W-2:0], ge};
        rem  <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/lssa_cell.sv
// ----------------------------------------------------------------------------
// lssa_cell
// One pixel of the strip store; shifts outward or rotates inward.
// ----------------------------------------------------------------------------
module lssa_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  lssa_pkg::cell_ctrl_t ctrl,
  input  lssa_pkg::color_t     shift_in,
  input  lssa_pkg::color_t     rot_in,
  output lssa_pkg::color_t     pix
);
  import lssa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (ctrl.shift) begin
      pix <= shift_in;
    end else if (ctrl.rotate) begin
      pix <= rot_in;
    end
  end

endmodule

### sv/led_strip_segment_animator.sv
// ----------------------------------------------------------------------------
// led_strip_segment_animator
// Plays a looping list of colour segments onto a 64-pixel strip store.
// ----------------------------------------------------------------------------
// Appends and clears take one transfer; an append that fits in the table then
// writes the segment table in the append state before the next transfer. A
// tick runs one division on the serial divider for the move, six more when the
// segment is faded and moves, then shifts the new pixels along the cell chain
// and emits every pixel, rotating the 64-cell chain once per emitted pixel;
// the output side can stall the emission.
module led_strip_segment_animator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] seg_red,
  input  logic [7:0] seg_green,
  input  logic [7:0] seg_blue,
  input  logic [15:0] seg_duration_ms,
  input  logic [7:0] seg_length,
  input  logic       seg_faded,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] pixel_index,
  output logic [7:0] pixel_red,
  output logic [7:0] pixel_green,
  output logic [7:0] pixel_blue,
  output logic       last_pixel
);
  import lssa_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_APPEND = 7'b0000010,
    ST_FETCH  = 7'b0000100,
    ST_CALC   = 7'b0001000,
    ST_SHIFT  = 7'b0010000,
    ST_WRAP   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     seg_count;
  logic [SEG_AW-1:0]    cur_seg;
  logic [DUR_W-1:0]     frame_count;
  logic [OFF_W-1:0]     shift_offset;
  color_t               prev_color;
  color_t               app_color;
  logic [15:0]          app_ms;
  logic [LEN_W-1:0]     app_len;
  logic                 app_faded;
  logic [SEG_W-1:0]     seg_mem [TABLE_DEPTH];
  logic [SEG_W-1:0]     seg_q;
  logic [2:0]           div_op;
  logic                 div_run;
  logic [6:0]           move_cnt;
  logic [7:0]           qv [6];
  logic [5:0]           emit_idx;

  color_t               seg_color;
  logic [DUR_W-1:0]     seg_dur;
  logic [LEN_W-1:0]     seg_len;
  logic                 seg_fade;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quot;
  logic [7:0]           comp;
  logic [DIV_NUM_W-1:0] mv;
  logic [MS_PROD_W-1:0] ms_prod;
  logic [MS_SCALED_W-1:0] ms_scaled;
  logic [MS_SCALED_W-1:0] ms_frames;
  logic [DUR_W-1:0]     frames;
  color_t               fill;
  color_t               pix [STRIP_PIXELS];
  cell_ctrl_t           cctrl;
  logic                 in_acc;
  logic                 out_acc;
  logic [CNT_W-1:0]     cur_next;

  assign {seg_color, seg_dur, seg_len, seg_fade} = seg_q;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (state == ST_EMIT);
  assign out_acc  = out_valid && !out_stall;

  assign pixel_index = emit_idx;
  assign pixel_red   = pix[0][23:16];
  assign pixel_green = pix[0][15:8];
  assign pixel_blue  = pix[0][7:0];
  assign last_pixel  = (emit_idx == 6'(STRIP_PIXELS - 1));

  always_comb begin
    case (div_op)
      3'd1:    comp = seg_color[23:16];
      3'd2:    comp = prev_color[23:16];
      3'd3:    comp = seg_color[15:8];
      3'd4:    comp = prev_color[15:8];
      3'd5:    comp = seg_color[7:0];
      3'd6:    comp = prev_color[7:0];
      default: comp = '0;
    endcase
    if (div_op == 3'd0) begin
      div_num = DIV_NUM_W'(seg_len * frame_count);
      div_den = seg_dur;
    end else begin
      div_num = DIV_NUM_W'(comp * frame_count);
      div_den = seg_dur;
    end
  end

  assign div_start = (state == ST_CALC) && !div_run;

  lssa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign mv = (div_quot > DIV_NUM_W'(shift_offset)) ?
              div_quot - DIV_NUM_W'(shift_offset) : '0;

  assign ms_prod   = MS_PROD_W'(app_ms) * MS_PROD_W'(FRAME_RATE);
  assign ms_scaled = MS_SCALED_W'(ms_prod) * MS_SCALED_W'(MS_RECIP);
  assign ms_frames = ms_scaled >> MS_SHIFT;

  always_comb begin
    if (ms_frames == '0) begin
      frames = DUR_W'(1);
    end else if (ms_frames > MS_SCALED_W'(DURATION_MAX)) begin
      frames = DUR_W'(DURATION_MAX);
    end else begin
      frames = ms_frames[DUR_W-1:0];
    end
  end

  always_comb begin
    if (seg_fade) begin
      fill[23:16] = prev_color[23:16] + qv[0] - qv[1];
      fill[15:8]  = prev_color[15:8] + qv[2] - qv[3];
      fill[7:0]   = prev_color[7:0] + qv[4] - qv[5];
    end else begin
      fill = seg_color;
    end
  end

  assign cur_next = CNT_W'(cur_seg) + 1'b1;

  assign cctrl.shift  = (state == ST_SHIFT);
  assign cctrl.rotate = out_acc;

  for (genvar gi = 0; gi < STRIP_PIXELS; gi++) begin : g_cell
    color_t sh_in;
    if (gi == 0) begin : g_front
      assign sh_in = fill;
    end else begin : g_body
      assign sh_in = pix[gi-1];
    end
    lssa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cctrl),
      .shift_in (sh_in),
      .rot_in   (pix[(gi + 1) % STRIP_PIXELS]),
      .pix      (pix[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (state == ST_APPEND) begin
      seg_mem[seg_count[SEG_AW-1:0]] <= {app_color, frames, app_len, app_faded};
    end
    if (state == ST_FETCH) begin
      seg_q <= seg_mem[cur_seg];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      app_color <= {seg_red, seg_green, seg_blue};
      app_ms    <= seg_duration_ms;
      app_len   <= (seg_length > 8'(STRIP_PIXELS)) ? LEN_W'(STRIP_PIXELS)
                                                   : seg_length[LEN_W-1:0];
      app_faded <= seg_faded;
    end
    if (state == ST_CALC && div_done && div_op != 3'd0) begin
      qv[div_op - 3'd1] <= div_quot[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seg_count    <= '0;
      cur_seg      <= '0;
      frame_count  <= '0;
      shift_offset <= '0;
      prev_color   <= '0;
      div_op       <= '0;
      div_run      <= 1'b0;
      move_cnt     <= '0;
      emit_idx     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (action == ACT_CLEAR) begin
              seg_count    <= '0;
              cur_seg      <= '0;
              frame_count  <= '0;
              shift_offset <= '0;
              prev_color   <= '0;
            end else if (action == ACT_APPEND) begin
              if (seg_count < CNT_W'(TABLE_DEPTH)) begin
                state <= ST_APPEND;
              end
            end else if (action == ACT_TICK && seg_count != '0) begin
              if (CNT_W'(cur_seg) >= seg_count) begin
                cur_seg <= '0;
              end
              state <= ST_FETCH;
            end
          end
        end
        ST_APPEND: begin
          seg_count <= seg_count + 1'b1;
          state     <= ST_IDLE;
        end
        ST_FETCH: begin
          frame_count <= frame_count + 1'b1;
          div_op      <= '0;
          state       <= ST_CALC;
        end
        ST_CALC: begin
          if (!div_run) begin
            div_run <= 1'b1;
          end else if (div_done) begin
            div_run <= 1'b0;
            if (div_op == 3'd0) begin
              shift_offset <= shift_offset + mv[OFF_W-1:0];
              move_cnt <= (mv > DIV_NUM_W'(STRIP_PIXELS)) ? 7'(STRIP_PIXELS)
                                                          : mv[6:0];
              if (mv == '0) begin
                state <= ST_WRAP;
              end else if (seg_fade) begin
                div_op <= 3'd1;
              end else begin
                state <= ST_SHIFT;
              end
            end else if (div_op == 3'd6) begin
              state <= ST_SHIFT;
            end else begin
              div_op <= div_op + 1'b1;
            end
          end
        end
        ST_SHIFT: begin
          move_cnt <= move_cnt - 1'b1;
          if (move_cnt == 7'd1) begin
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (frame_count == seg_dur) begin
            frame_count  <= '0;
            shift_offset <= '0;
            prev_color   <= seg_color;
            cur_seg      <= (cur_next == seg_count) ? '0 : cur_next[SEG_AW-1:0];
          end
          emit_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_acc) begin
            emit_idx <= emit_idx + 1'b1;
            if (last_pixel) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### sv/lssa_checker.sv
// ----------------------------------------------------------------------------
// lssa_checker
// Port-level checks for the LED strip segment animator.
// ----------------------------------------------------------------------------
`include "led_strip_segment_animator_assert.svh"

module lssa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic [7:0]  seg_red,
  input logic [7:0]  seg_green,
  input logic [7:0]  seg_blue,
  input logic [15:0] seg_duration_ms,
  input logic [7:0]  seg_length,
  input logic        seg_faded,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  pixel_index,
  input logic [7:0]  pixel_red,
  input logic [7:0]  pixel_green,
  input logic [7:0]  pixel_blue,
  input logic        last_pixel
);

  `LSSA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel_index) && $stable(pixel_red) && $stable(pixel_green) && $stable(pixel_blue))
  `LSSA_ASSERT_NXT(a_no_early_out, clk, rst, in_valid && !in_stall, !out_valid)
  `LSSA_ASSERT_IMP(a_busy_emit, clk, rst, out_valid, in_stall)
  `LSSA_ASSERT_NXT(a_frame_cont, clk, rst, out_valid && !out_stall && !last_pixel, out_valid)

endmodule

bind led_strip_segment_animator lssa_checker u_lssa_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// LED strip segment animator testbench
// Drives clear, append, tick and unused-action transfers into the animator,
// predicts every emitted pixel from its own copy of the segment table and
// pixel store, and compares each output transfer field by field under random
// idling and a long hold-off on the output side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lssa_pkg::*;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] ms;
    logic [7:0]  len;
    logic        faded;
  } item_t;

  typedef struct packed {
    logic [5:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_TICK;
  logic [7:0]  seg_red = '0;
  logic [7:0]  seg_green = '0;
  logic [7:0]  seg_blue = '0;
  logic [15:0] seg_duration_ms = '0;
  logic [7:0]  seg_length = '0;
  logic        seg_faded = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  pixel_index;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic        last_pixel;

  led_strip_segment_animator u_dut (.*);

  // Animator state as predicted.
  color_t      strip [STRIP_PIXELS];
  color_t      seg_color [TABLE_DEPTH];
  logic [10:0] seg_frames [TABLE_DEPTH];
  logic [6:0]  seg_len [TABLE_DEPTH];
  logic        seg_fade [TABLE_DEPTH];
  int unsigned seg_total, seg_now, frame_no, offset;
  color_t      prev_color;

  pixel_t      pixel_queue [$];
  int          errors = 0;
  int          seen = 0;
  int          send_idle = 30, recv_idle = 65;
  bit          hold_off = 1'b0;
  bit          sending_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [7:0] mix(input int unsigned a, input int unsigned b,
                                     input int unsigned f, input int unsigned d);
    int unsigned v;
    v = a + (b * f) / d - (a * f) / d;
    return v[7:0];
  endfunction

  task automatic predict_item(input item_t it);
    int unsigned frames, target, move, d;
    color_t fill;
    case (it.act)
      ACT_CLEAR: begin
        seg_total = 0;
        seg_now = 0;
        prev_color = '0;
        frame_no = 0;
        offset = 0;
      end
      ACT_APPEND: begin
        if (seg_total < TABLE_DEPTH) begin
          frames = it.ms * FRAME_RATE / MS_PER_SECOND;
          if (frames == 0) frames = 1;
          if (frames > DURATION_MAX) frames = DURATION_MAX;
          seg_color[seg_total] = {it.red, it.green, it.blue};
          seg_frames[seg_total] = 11'(frames);
          seg_len[seg_total] = 7'((it.len > STRIP_PIXELS) ? STRIP_PIXELS : it.len);
          seg_fade[seg_total] = it.faded;
          seg_total++;
        end
      end
      ACT_TICK: begin
        if (seg_total != 0) begin
          if (seg_now >= seg_total) seg_now = 0;
          d = seg_frames[seg_now];
          frame_no = (frame_no + 1) & 11'h7ff;
          target = seg_len[seg_now] * frame_no / d;
          move = (target > offset) ? target - offset : 0;
          offset = (offset + move) & 7'h7f;
          if (move != 0) begin
            for (int k = STRIP_PIXELS - 1; k >= 0 && k >= move; k--)
              strip[k] = strip[k - move];
            fill = seg_fade[seg_now]
              ? {mix(prev_color[23:16], seg_color[seg_now][23:16], frame_no, d),
                 mix(prev_color[15:8], seg_color[seg_now][15:8], frame_no, d),
                 mix(prev_color[7:0], seg_color[seg_now][7:0], frame_no, d)}
              : seg_color[seg_now];
            for (int i = 0; i < move && i < STRIP_PIXELS; i++) strip[i] = fill;
          end
          if (frame_no == d) begin
            frame_no = 0;
            offset = 0;
            prev_color = seg_color[seg_now];
            seg_now = (seg_now + 1) % seg_total;
          end
          for (int i = 0; i < STRIP_PIXELS; i++)
            pixel_queue.push_back({6'(i), strip[i], i == STRIP_PIXELS - 1});
        end
      end
      default: ;
    endcase
  endtask

  task automatic send(input item_t it);
    in_valid <= 1'b1;
    {action, seg_red, seg_green, seg_blue, seg_duration_ms, seg_length, seg_faded} <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic item_t rand_item(input logic [1:0] act);
    item_t it;
    it = $bits(item_t)'({$urandom, $urandom});
    it.act = act;
    case ($urandom_range(3))
      0: it.ms = 16'($urandom_range(0, 200));
      1: it.ms = 16'($urandom_range(0, 1500));
      2: it.ms = 16'($urandom);
      default: it.ms = 16'($urandom_range(60000, 65535));
    endcase
    // Long segments are mostly kept short enough to finish.
    if (it.ms > 3000 && $urandom_range(9) != 0) it.ms = 16'($urandom_range(0, 3000));
    if ($urandom_range(2) == 0) it.len = 8'($urandom_range(0, 80));
    return it;
  endfunction

  // Directed rows: action, colour, duration in ms, length, faded.
  item_t directed [] = '{
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_UNUSED, 8'hff, 8'hff, 8'hff, 16'hffff, 8'hff, 1'b1},
    {ACT_APPEND, 8'hff, 8'h00, 8'h80, 16'd100, 8'd6, 1'b0},
    {ACT_APPEND, 8'h00, 8'hff, 8'h01, 16'd0, 8'd255, 1'b1},
    {ACT_APPEND, 8'h12, 8'h34, 8'h56, 16'd200, 8'd0, 1'b1},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_CLEAR, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_APPEND, 8'hff, 8'hff, 8'hff, 16'd33, 8'd64, 1'b1},
    {ACT_APPEND, 8'h80, 8'h40, 8'h20, 16'd66, 8'd65, 1'b1},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0},
    {ACT_APPEND, 8'h01, 8'h02, 8'h03, 16'hffff, 8'd1, 1'b0},
    {ACT_CLEAR, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 1'b0}
  };

  initial begin
    for (int i = 0; i < STRIP_PIXELS; i++) strip[i] = '0;
    seg_total = 0; seg_now = 0; frame_no = 0; offset = 0; prev_color = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      send(directed[i]);
      // A tick and an unused action with an empty table emit nothing.
      if (i == 2 && seen != 0) report("pixels before any segment", seen, 0);
    end
    // Fill the table past capacity, then play.
    for (int n = 0; n < 66; n++) send(rand_item(ACT_APPEND));
    for (int n = 0; n < 8; n++) send(rand_item(ACT_TICK));
    hold_off = 1'b1;
    for (int n = 0; n < 3; n++) send(rand_item(ACT_TICK));
    hold_off = 1'b0;
    for (int n = 0; n < 110; n++) begin
      if (n == 40) begin send_idle = 65; recv_idle = 30; end
      if (n == 80) begin send_idle = 0; recv_idle = 0; end
      case ($urandom_range(19))
        0: begin
          send(rand_item(ACT_CLEAR));
          repeat ($urandom_range(1, 4)) send(rand_item(ACT_APPEND));
        end
        1: send(rand_item(ACT_APPEND));
        2: send(rand_item(ACT_UNUSED));
        default: send(rand_item(ACT_TICK));
      endcase
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_off);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin
    pixel_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        seen++;
        if (pixel_queue.size() == 0) begin
          report("unexpected pixel", pixel_index, -1);
        end else begin
          want = pixel_queue.pop_front();
          if (pixel_index !== want.index) report("pixel_index", pixel_index, want.index);
          if (pixel_red !== want.red) report("pixel_red", pixel_red, want.red);
          if (pixel_green !== want.green) report("pixel_green", pixel_green, want.green);
          if (pixel_blue !== want.blue) report("pixel_blue", pixel_blue, want.blue);
          if (last_pixel !== want.last) report("last_pixel", last_pixel, want.last);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    wait (pixel_queue.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
